// ----- rtl/ray_sphere_intersection_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ray against sphere intersection unit
// Each macro expects signals named clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECTION_UNIT_ASSERT_SVH
`define RAY_SPHERE_INTERSECTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared types for the ray against sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  typedef struct packed {
    logic miss;
    logic h_nonpos;
    logic c_neg;
    logic c_zero;
  } ctl_t;

endpackage

// ----- rtl/rsi_front.sv -----
// ----------------------------------------------------------------------------
// rsi_front
// Seven stages: offset from the centre, dot products, quadratic terms,
// magnitudes, partial products, squared terms and the discriminant.
// ----------------------------------------------------------------------------
module rsi_front #(
  parameter int N = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  i_valid,
  input  logic signed [N-1:0]   origin_x,
  input  logic signed [N-1:0]   origin_y,
  input  logic signed [N-1:0]   origin_z,
  input  logic signed [N-1:0]   dir_x,
  input  logic signed [N-1:0]   dir_y,
  input  logic signed [N-1:0]   dir_z,
  input  logic signed [N-1:0]   center_x,
  input  logic signed [N-1:0]   center_y,
  input  logic signed [N-1:0]   center_z,
  input  logic [N-2:0]          radius,
  output logic                  o_valid,
  output rsi_pkg::ctl_t         o_ctl,
  output logic [2*N:0]          o_hm,
  output logic [2*N-1:0]        o_a,
  output logic [4*N+2:0]        o_disc
);

  localparam int OW = N + 1;
  localparam int PW = 2 * N + 1;
  localparam int AW = 2 * N;
  localparam int HW = 2 * N + 2;
  localparam int CW = 2 * N + 3;
  localparam int HM = 2 * N + 1;
  localparam int CM = 2 * N + 2;
  localparam int LW = N + 1;
  localparam int PD = 4 * N + 2;
  localparam int DW = 4 * N + 3;

  logic signed [N-1:0] org[3];
  logic signed [N-1:0] dir[3];
  logic signed [N-1:0] cen[3];

  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;
  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;

  // Stage 1
  logic                 v1_r;
  logic signed [OW-1:0] oc_r[3];
  logic signed [N-1:0]  d_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        oc_r[k] <= OW'(org[k]) - OW'(cen[k]);
        d_r[k]  <= dir[k];
      end
    end
  end

  // Stage 2
  logic signed [AW-1:0]   dd_w[3];
  logic signed [PW-1:0]   ocd_w[3];
  logic signed [2*OW-1:0] oo_w[3];
  logic [2*N-3:0]         rr_w;
  logic                   v2_r;
  logic [AW-1:0]          dd_r[3];
  logic signed [PW-1:0]   ocd_r[3];
  logic [2*N:0]           oo_r[3];
  logic [2*N-3:0]         rr_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd_w[k]  = d_r[k] * d_r[k];
      ocd_w[k] = oc_r[k] * d_r[k];
      oo_w[k]  = oc_r[k] * oc_r[k];
    end
  end

  assign rr_w = radius * radius;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dd_r[k]  <= dd_w[k];
        ocd_r[k] <= ocd_w[k];
        oo_r[k]  <= oo_w[k][2*N:0];
      end
      rr_r <= rr_w;
    end
  end

  // Stage 3
  logic                 v3_r;
  logic [AW-1:0]        a3_r;
  logic signed [HW-1:0] h3_r;
  logic signed [CW-1:0] c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3_r <= dd_r[0] + dd_r[1] + dd_r[2];
      h3_r <= HW'(ocd_r[0]) + HW'(ocd_r[1]) + HW'(ocd_r[2]);
      c3_r <= CW'(oo_r[0]) + CW'(oo_r[1]) + CW'(oo_r[2]) - CW'(rr_r);
    end
  end

  // Stage 4
  logic signed [HW-1:0] h_neg;
  logic signed [CW-1:0] c_neg;
  logic                 v4_r;
  rsi_pkg::ctl_t        ctl4_r;
  logic [AW-1:0]        a4_r;
  logic [HM-1:0]        hm4_r;
  logic [CM-1:0]        cm4_r;

  assign h_neg = -h3_r;
  assign c_neg = -c3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a4_r            <= a3_r;
      hm4_r           <= h3_r[HW-1] ? h_neg[HM-1:0] : h3_r[HM-1:0];
      cm4_r           <= c3_r[CW-1] ? c_neg[CM-1:0] : c3_r[CM-1:0];
      ctl4_r.miss     <= (a3_r == '0);
      ctl4_r.h_nonpos <= h3_r[HW-1] || (h3_r == '0);
      ctl4_r.c_neg    <= c3_r[CW-1];
      ctl4_r.c_zero   <= (c3_r == '0);
    end
  end

  // Stage 5
  logic                v5_r;
  rsi_pkg::ctl_t       ctl5_r;
  logic [AW-1:0]       a5_r;
  logic [HM-1:0]       hm5_r;
  logic [2*LW-1:0]     hll_r;
  logic [2*LW-1:0]     hlh_r;
  logic [2*LW-1:0]     hhh_r;
  logic [2*LW-1:0]     all_r;
  logic [2*LW-1:0]     alh_r;
  logic [2*LW-1:0]     ahl_r;
  logic [2*LW-1:0]     ahh_r;
  logic [LW-1:0]       hl;
  logic [HM-LW-1:0]    hh;
  logic [LW-1:0]       al;
  logic [AW-LW-1:0]    ah;
  logic [LW-1:0]       cl;
  logic [CM-LW-1:0]    ch;

  assign hl = hm4_r[LW-1:0];
  assign hh = hm4_r[HM-1:LW];
  assign al = a4_r[LW-1:0];
  assign ah = a4_r[AW-1:LW];
  assign cl = cm4_r[LW-1:0];
  assign ch = cm4_r[CM-1:LW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl5_r <= ctl4_r;
      a5_r   <= a4_r;
      hm5_r  <= hm4_r;
      hll_r  <= (2*LW)'(hl) * (2*LW)'(hl);
      hlh_r  <= (2*LW)'(hl) * (2*LW)'(hh);
      hhh_r  <= (2*LW)'(hh) * (2*LW)'(hh);
      all_r  <= (2*LW)'(al) * (2*LW)'(cl);
      alh_r  <= (2*LW)'(al) * (2*LW)'(ch);
      ahl_r  <= (2*LW)'(ah) * (2*LW)'(cl);
      ahh_r  <= (2*LW)'(ah) * (2*LW)'(ch);
    end
  end

  // Stage 6
  logic          v6_r;
  rsi_pkg::ctl_t ctl6_r;
  logic [AW-1:0] a6_r;
  logic [HM-1:0] hm6_r;
  logic [PD-1:0] h2_r;
  logic [PD-1:0] ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl6_r <= ctl5_r;
      a6_r   <= a5_r;
      hm6_r  <= hm5_r;
      h2_r   <= PD'(hll_r) + (PD'(hlh_r) << (LW + 1)) + (PD'(hhh_r) << (2 * LW));
      ac_r   <= PD'(all_r) + ((PD'(alh_r) + PD'(ahl_r)) << LW) + (PD'(ahh_r) << (2 * LW));
    end
  end

  // Stage 7
  logic          v7_r;
  rsi_pkg::ctl_t ctl7_r;
  logic [AW-1:0] a7_r;
  logic [HM-1:0] hm7_r;
  logic [DW-1:0] disc7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl7_r.miss     <= ctl6_r.miss || (!ctl6_r.c_neg && (ac_r > h2_r));
      ctl7_r.h_nonpos <= ctl6_r.h_nonpos;
      ctl7_r.c_neg    <= ctl6_r.c_neg;
      ctl7_r.c_zero   <= ctl6_r.c_zero;
      a7_r            <= a6_r;
      hm7_r           <= hm6_r;
      disc7_r         <= ctl6_r.c_neg ? (DW'(h2_r) + DW'(ac_r)) : (DW'(h2_r) - DW'(ac_r));
    end
  end

  assign o_valid = v7_r;
  assign o_ctl   = ctl7_r;
  assign o_hm    = hm7_r;
  assign o_a     = a7_r;
  assign o_disc  = disc7_r;

endmodule

// ----- rtl/rsi_sqrt.sv -----
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, one result bit resolved in each stage.
// ----------------------------------------------------------------------------
module rsi_sqrt #(
  parameter int N = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            i_valid,
  input  rsi_pkg::ctl_t   i_ctl,
  input  logic [2*N:0]    i_hm,
  input  logic [2*N-1:0]  i_a,
  input  logic [4*N+2:0]  i_disc,
  output logic            o_valid,
  output rsi_pkg::ctl_t   o_ctl,
  output logic [2*N:0]    o_hm,
  output logic [2*N-1:0]  o_a,
  output logic [2*N+1:0]  o_root
);

  localparam int DW = 4 * N + 3;
  localparam int EW = DW + 1;
  localparam int SW = (DW + 1) / 2;
  localparam int HM = 2 * N + 1;
  localparam int AW = 2 * N;

  logic          v_r[SW];
  rsi_pkg::ctl_t ctl_r[SW];
  logic [HM-1:0] hm_r[SW];
  logic [AW-1:0] a_r[SW];
  logic [DW-1:0] rem_r[SW];
  logic [SW-1:0] root_r[SW];

  logic          v_in[SW];
  rsi_pkg::ctl_t ctl_in[SW];
  logic [HM-1:0] hm_in[SW];
  logic [AW-1:0] a_in[SW];
  logic [DW-1:0] rem_in[SW];
  logic [SW-1:0] root_in[SW];

  for (genvar g = 0; g < SW; g++) begin : g_stage
    localparam int B = SW - 1 - g;
    logic [EW-1:0] trial;
    logic          ge;

    if (g == 0) begin : g_first
      assign v_in[g]    = i_valid;
      assign ctl_in[g]  = i_ctl;
      assign hm_in[g]   = i_hm;
      assign a_in[g]    = i_a;
      assign rem_in[g]  = i_disc;
      assign root_in[g] = '0;
    end else begin : g_next
      assign v_in[g]    = v_r[g-1];
      assign ctl_in[g]  = ctl_r[g-1];
      assign hm_in[g]   = hm_r[g-1];
      assign a_in[g]    = a_r[g-1];
      assign rem_in[g]  = rem_r[g-1];
      assign root_in[g] = root_r[g-1];
    end

    assign trial = (EW'(root_in[g]) << (B + 1)) | (EW'(1) << (2 * B));
    assign ge    = (EW'(rem_in[g]) >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[g]  <= ctl_in[g];
        hm_r[g]   <= hm_in[g];
        a_r[g]    <= a_in[g];
        rem_r[g]  <= ge ? (rem_in[g] - trial[DW-1:0]) : rem_in[g];
        root_r[g] <= root_in[g] | (SW'(ge) << B);
      end
    end
  end

  assign o_valid = v_r[SW-1];
  assign o_ctl   = ctl_r[SW-1];
  assign o_hm    = hm_r[SW-1];
  assign o_a     = a_r[SW-1];
  assign o_root  = root_r[SW-1];

endmodule

// ----- rtl/rsi_div.sv -----
// ----------------------------------------------------------------------------
// rsi_div
// Root selection, saturation check and a pipelined restoring divider that
// resolves one quotient bit in each stage.
// ----------------------------------------------------------------------------
module rsi_div #(
  parameter int N = 32,
  parameter int F = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            i_valid,
  input  rsi_pkg::ctl_t   i_ctl,
  input  logic [2*N:0]    i_hm,
  input  logic [2*N-1:0]  i_a,
  input  logic [2*N+1:0]  i_root,
  output logic            o_valid,
  output logic            o_hit,
  output logic [N-2:0]    o_distance
);

  localparam int NW  = 2 * N + 3;
  localparam int NSW = NW + F;
  localparam int AW  = 2 * N;
  localparam int QW  = N - 1;
  localparam int RW  = (NSW > AW + QW) ? NSW : AW + QW;

  // Numerator selection
  logic [NW-1:0] hm_x;
  logic [NW-1:0] s_x;
  logic [NW-1:0] num;
  logic          sel_miss;

  assign hm_x = NW'(i_hm);
  assign s_x  = NW'(i_root);

  always_comb begin
    sel_miss = 1'b0;
    num      = '0;
    priority if (i_ctl.h_nonpos && !i_ctl.c_neg) begin
      num = hm_x - s_x;
    end else if (i_ctl.h_nonpos) begin
      num = hm_x + s_x;
    end else if (i_ctl.c_neg || i_ctl.c_zero) begin
      num = s_x - hm_x;
    end else begin
      sel_miss = 1'b1;
    end
  end

  logic          v0_r;
  logic          miss0_r;
  logic [AW-1:0] a0_r;
  logic [RW-1:0] rem0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss0_r <= i_ctl.miss || sel_miss;
      a0_r    <= i_a;
      rem0_r  <= RW'(num) << F;
    end
  end

  // Saturation check
  logic          v1_r;
  logic          miss1_r;
  logic          ovf1_r;
  logic [AW-1:0] a1_r;
  logic [RW-1:0] rem1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss1_r <= miss0_r;
      ovf1_r  <= (rem0_r >= (RW'(a0_r) << QW));
      a1_r    <= a0_r;
      rem1_r  <= rem0_r;
    end
  end

  // Quotient stages
  logic          v_r[QW];
  logic          miss_r[QW];
  logic          ovf_r[QW];
  logic [AW-1:0] a_r[QW];
  logic [RW-1:0] rem_r[QW];
  logic [QW-1:0] q_r[QW];

  logic          v_in[QW];
  logic          miss_in[QW];
  logic          ovf_in[QW];
  logic [AW-1:0] a_in[QW];
  logic [RW-1:0] rem_in[QW];
  logic [QW-1:0] q_in[QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int B = QW - 1 - g;
    logic [RW-1:0] trial;
    logic          ge;

    if (g == 0) begin : g_first
      assign v_in[g]    = v1_r;
      assign miss_in[g] = miss1_r;
      assign ovf_in[g]  = ovf1_r;
      assign a_in[g]    = a1_r;
      assign rem_in[g]  = rem1_r;
      assign q_in[g]    = '0;
    end else begin : g_next
      assign v_in[g]    = v_r[g-1];
      assign miss_in[g] = miss_r[g-1];
      assign ovf_in[g]  = ovf_r[g-1];
      assign a_in[g]    = a_r[g-1];
      assign rem_in[g]  = rem_r[g-1];
      assign q_in[g]    = q_r[g-1];
    end

    assign trial = RW'(a_in[g]) << B;
    assign ge    = (rem_in[g] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        miss_r[g] <= miss_in[g];
        ovf_r[g]  <= ovf_in[g];
        a_r[g]    <= a_in[g];
        rem_r[g]  <= ge ? (rem_in[g] - trial) : rem_in[g];
        q_r[g]    <= q_in[g] | (QW'(ge) << B);
      end
    end
  end

  assign o_valid    = v_r[QW-1];
  assign o_hit      = !miss_r[QW-1];
  assign o_distance = miss_r[QW-1] ? '0 : (ovf_r[QW-1] ? '1 : q_r[QW-1]);

endmodule

// ----- rtl/ray_sphere_intersection_unit.sv -----
// ----------------------------------------------------------------------------
// ray_sphere_intersection_unit
// Tests a stream of rays against one configured sphere and returns the
// nearest non-negative hit distance in fixed point.
// ----------------------------------------------------------------------------
// Channel   Handshake                   Payload
// in_       in_valid / in_ready         origin x/y/z, direction x/y/z
// out_      out_valid / out_ready       hit, distance
// cfg_      cfg_psel/penable/pready     centre x/y/z, radius (APB style)
//
// One ray is taken in every cycle while no result waits on out_ready; the
// square root and the divider each resolve one bit per stage.
// All stages advance together and hold while a result waits on out_ready.
// Reset clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module ray_sphere_intersection_unit #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_BITS-1:0]          in_origin_x,
  input  logic signed [COORD_BITS-1:0]          in_origin_y,
  input  logic signed [COORD_BITS-1:0]          in_origin_z,
  input  logic signed [COORD_BITS-1:0]          in_dir_x,
  input  logic signed [COORD_BITS-1:0]          in_dir_y,
  input  logic signed [COORD_BITS-1:0]          in_dir_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_hit,
  output logic [COORD_BITS-2:0]                 out_distance,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [((COORD_BITS > 32) ? 5 : 4)-1:0] cfg_paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0] cfg_pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0] cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int N      = COORD_BITS;
  localparam int DATA_W = (COORD_BITS > 32) ? 64 : 32;
  localparam int ADDR_W = (COORD_BITS > 32) ? 5 : 4;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_t;

  logic signed [N-1:0] cen_x_r;
  logic signed [N-1:0] cen_y_r;
  logic signed [N-1:0] cen_z_r;
  logic [N-2:0]        rad_r;
  logic                wr_en;
  reg_idx_t            reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = reg_idx_t'(cfg_paddr[ADDR_W-1 -: 2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_x_r <= '0;
      cen_y_r <= '0;
      cen_z_r <= '0;
      rad_r   <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CENTER_X: cen_x_r <= cfg_pwdata[N-1:0];
        REG_CENTER_Y: cen_y_r <= cfg_pwdata[N-1:0];
        REG_CENTER_Z: cen_z_r <= cfg_pwdata[N-1:0];
        REG_RADIUS:   rad_r   <= cfg_pwdata[N-2:0];
        default:      rad_r   <= rad_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CENTER_X: cfg_prdata = DATA_W'(cen_x_r);
      REG_CENTER_Y: cfg_prdata = DATA_W'(cen_y_r);
      REG_CENTER_Z: cfg_prdata = DATA_W'(cen_z_r);
      REG_RADIUS:   cfg_prdata = DATA_W'(rad_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Pipeline advance
  logic adv;
  logic out_valid_r;
  logic out_hit_r;
  logic [N-2:0] out_distance_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  logic            fr_valid;
  rsi_pkg::ctl_t   fr_ctl;
  logic [2*N:0]    fr_hm;
  logic [2*N-1:0]  fr_a;
  logic [4*N+2:0]  fr_disc;

  rsi_front #(.N(N)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .i_valid  (in_valid),
    .origin_x (in_origin_x),
    .origin_y (in_origin_y),
    .origin_z (in_origin_z),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .center_x (cen_x_r),
    .center_y (cen_y_r),
    .center_z (cen_z_r),
    .radius   (rad_r),
    .o_valid  (fr_valid),
    .o_ctl    (fr_ctl),
    .o_hm     (fr_hm),
    .o_a      (fr_a),
    .o_disc   (fr_disc)
  );

  logic            sq_valid;
  rsi_pkg::ctl_t   sq_ctl;
  logic [2*N:0]    sq_hm;
  logic [2*N-1:0]  sq_a;
  logic [2*N+1:0]  sq_root;

  rsi_sqrt #(.N(N)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .i_valid (fr_valid),
    .i_ctl   (fr_ctl),
    .i_hm    (fr_hm),
    .i_a     (fr_a),
    .i_disc  (fr_disc),
    .o_valid (sq_valid),
    .o_ctl   (sq_ctl),
    .o_hm    (sq_hm),
    .o_a     (sq_a),
    .o_root  (sq_root)
  );

  logic         dv_valid;
  logic         dv_hit;
  logic [N-2:0] dv_distance;

  rsi_div #(.N(N), .F(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .i_valid    (sq_valid),
    .i_ctl      (sq_ctl),
    .i_hm       (sq_hm),
    .i_a        (sq_a),
    .i_root     (sq_root),
    .o_valid    (dv_valid),
    .o_hit      (dv_hit),
    .o_distance (dv_distance)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r      <= dv_hit;
      out_distance_r <= dv_distance;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_distance_r;

endmodule

// ----- rtl/rsi_checker.sv -----
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks on the ray against sphere intersection unit.
// ----------------------------------------------------------------------------
`include "ray_sphere_intersection_unit_assert.svh"

module rsi_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_hit,
  input logic [COORD_BITS-2:0] out_distance
);

  `RSI_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, out_distance == '0, "miss beat with nonzero distance")
  `RSI_ASSERT_IMP(a_ready_empty, !out_valid, in_ready, "input not ready while output is empty")
  `RSI_ASSERT_IMP(a_stall_blocks, out_valid && !out_ready, !in_ready, "input taken during an output stall")
  `RSI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hit) && $stable(out_distance), "stalled result beat changed")

endmodule

bind ray_sphere_intersection_unit rsi_checker #(.COORD_BITS(COORD_BITS)) u_rsi_checker (.*);

// ----- sim/ray_sphere_intersection_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray against sphere intersection unit testbench
// Drives rays through the valid/ready input channel against spheres set over
// the configuration port, and compares every result beat with a wide-integer
// predictor of the quadratic root selection, truncating division and saturation.
// ----------------------------------------------------------------------------
module ray_sphere_intersection_unit_tb;

  localparam int CB = 32;
  localparam int FB = 16;
  localparam int LATENCY = 3 * CB + 11;
  localparam logic [3:0] ADDR_CX = 4'd0;
  localparam logic [3:0] ADDR_CY = 4'd4;
  localparam logic [3:0] ADDR_CZ = 4'd8;
  localparam logic [3:0] ADDR_RAD = 4'd12;
  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
    logic        chk;
    logic        hit;
    logic [30:0] distance;
  } ray_row_t;

  typedef struct {
    logic        hit;
    logic [30:0] distance;
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [30:0] out_distance;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  logic signed [31:0] sph_cx = 0, sph_cy = 0, sph_cz = 0;
  logic [30:0] sph_r = 0;
  isect_t pending_hits[$];
  int errors = 0;
  int idle_pct = 27;
  ray_row_t dir_rows[$];

  ray_sphere_intersection_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (.*);

  always #2 clk = ~clk;

  function automatic logic [255:0] isqrt(input logic [255:0] n);
    logic [255:0] r, c;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      c = r | (256'd1 << i);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic isect_t trace_sphere(input ray_row_t rr);
    logic signed [255:0] oc[3], d[3], a, h, c, disc, s, num, q;
    isect_t res;
    res.hit = 1'b0;
    res.distance = '0;
    d[0] = rr.dx; d[1] = rr.dy; d[2] = rr.dz;
    oc[0] = 256'(signed'(rr.ox)) - 256'(signed'(sph_cx));
    oc[1] = 256'(signed'(rr.oy)) - 256'(signed'(sph_cy));
    oc[2] = 256'(signed'(rr.oz)) - 256'(signed'(sph_cz));
    a = 0; h = 0; c = 0;
    for (int k = 0; k < 3; k++) begin
      a += d[k] * d[k];
      h += oc[k] * d[k];
      c += oc[k] * oc[k];
    end
    if (a == 0) return res;
    c -= $signed({225'd0, sph_r}) * $signed({225'd0, sph_r});
    disc = h * h - a * c;
    if (disc < 0) return res;
    s = $signed(isqrt(disc));
    if (h <= 0 && c >= 0) num = -h - s;
    else if (h <= 0 || c <= 0) num = -h + s;
    else return res;
    q = (num <<< FB) / a;
    res.hit = 1'b1;
    res.distance = (q > CMAX) ? 31'h7fffffff : q[30:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (addr)
      ADDR_CX: sph_cx = val;
      ADDR_CY: sph_cy = val;
      ADDR_CZ: sph_cz = val;
      default: sph_r = val[30:0];
    endcase
  endtask

  task automatic set_sphere(input logic signed [31:0] x, y, z, input logic [30:0] r);
    write_reg(ADDR_CX, x);
    write_reg(ADDR_CY, y);
    write_reg(ADDR_CZ, z);
    write_reg(ADDR_RAD, {1'b0, r});
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic send_ray(input ray_row_t rr);
    isect_t e;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_x <= rr.ox; in_origin_y <= rr.oy; in_origin_z <= rr.oz;
    in_dir_x <= rr.dx; in_dir_y <= rr.dy; in_dir_z <= rr.dz;
    e = trace_sphere(rr);
    if (rr.chk && (e.hit !== rr.hit || e.distance !== rr.distance))
      report_mismatch("directed row", {e.hit, e.distance}, {rr.hit, rr.distance});
    pending_hits.push_back(e);
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [31:0] rnd_coord(input int span);
    case ($urandom_range(9))
      0: return $urandom;
      1: return CMAX;
      2: return CMIN;
      default: return $signed($urandom_range(2 * span)) - span;
    endcase
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected beat", {out_hit, out_distance}, '0);
      end else begin
        if (out_hit !== pending_hits[0].hit)
          report_mismatch("hit", out_hit, pending_hits[0].hit);
        if (out_distance !== pending_hits[0].distance)
          report_mismatch("distance", out_distance, pending_hits[0].distance);
        void'(pending_hits.pop_front());
      end
    end
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    ray_row_t rr;
    // origin, direction, check, hit, distance
    dir_rows = '{
      '{0, 0, 0, 0, 0, 0, 1, 0, 0},
      '{-5 * ONE, 0, 0, ONE, 0, 0, 1, 1, 31'(4 * ONE)},
      '{0, 0, 0, ONE, 0, 0, 1, 1, 31'(ONE)},
      '{5 * ONE, 0, 0, ONE, 0, 0, 1, 0, 0},
      '{-5 * ONE, ONE, 0, ONE, 0, 0, 1, 1, 31'(5 * ONE)},
      '{-5 * ONE, 2 * ONE, 0, ONE, 0, 0, 1, 0, 0},
      '{-5 * ONE, 0, 0, 0, 0, 0, 1, 0, 0},
      '{CMIN, 0, 0, 1, 0, 0, 1, 1, 31'h7fffffff},
      '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, 0, 0},
      '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0, 0, 0},
      '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 0, 0, 0},
      '{-5 * ONE, 0, 0, CMIN, 0, 0, 1, 0, 0},
      '{0, -5 * ONE, 0, 0, 3, 0, 0, 0, 0},
      '{ONE, 0, 0, ONE, 0, 0, 1, 1, 0},
      '{32'h0000ffff, 32'hffff0001, -1, 1, -1, 1, 0, 0, 0}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    drain();
    // After reset the sphere is a point at the origin.
    send_ray(dir_rows[0]);
    send_ray('{-ONE, 0, 0, ONE, 0, 0, 1, 1, 31'(ONE)});
    drain();
    set_sphere(0, 0, 0, 31'(ONE));
    foreach (dir_rows[i]) if (i > 0) send_ray(dir_rows[i]);
    drain();
    set_sphere(CMAX, CMIN, CMAX, 31'h7fffffff);
    for (int i = 0; i < 5; i++) send_ray(dir_rows[8 + i]);
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      int span;
      span = (ph == 3) ? 32'h7fffffff : (32 << (3 * ph));
      idle_pct = (ph == 2) ? 0 : 27;
      if (ph == 6) set_sphere(CMIN, CMAX, CMIN, 0);
      else set_sphere(rnd_coord(span), rnd_coord(span), rnd_coord(span),
                      31'($urandom_range(span)));
      for (int n = 0; n < 100; n++) begin
        rr.chk = 1'b0; rr.hit = 1'b0; rr.distance = '0;
        rr.ox = rnd_coord(span); rr.oy = rnd_coord(span); rr.oz = rnd_coord(span);
        if (n % 3 != 0) begin
          // Aim near the centre so that most rays meet the sphere.
          rr.dx = sph_cx - rr.ox + $signed($urandom_range(8)) - 4;
          rr.dy = sph_cy - rr.oy + $signed($urandom_range(8)) - 4;
          rr.dz = sph_cz - rr.oz + $signed($urandom_range(8)) - 4;
          if (n % 5 == 0) begin
            rr.dx = -rr.dx; rr.dy = -rr.dy; rr.dz = -rr.dz;
          end
        end else begin
          rr.dx = rnd_coord(span); rr.dy = rnd_coord(span); rr.dz = rnd_coord(span);
        end
        send_ray(rr);
        if (n == 50 && ph == 1) begin
          in_valid <= 1'b0;
          while (pending_hits.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rsi_pkg.sv
rtl/rsi_front.sv
rtl/rsi_sqrt.sv
rtl/rsi_div.sv
rtl/ray_sphere_intersection_unit.sv
rtl/rsi_checker.sv
sim/ray_sphere_intersection_unit_tb.sv
